// ===== sv/rhh_pkg.sv =====
// ============================================================================
// rhh_pkg
// Shared types and constants for the Robin Hood hash table.
// ============================================================================
package rhh_pkg;

    localparam int SLOTS      = 1024;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int HASH_BITS  = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int PL_W       = CNT_W;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [HASH_BITS-1:0]  hash;
        logic [PL_W-1:0]       plen;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_FRD,
        S_FCHK,
        S_PRD,
        S_PCHK,
        S_DRD,
        S_DCHK,
        S_RESP
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load_req;     // capture request
        logic idx_home;     // index <- home slot
        logic idx_inc;      // index <- index + 1
        logic probe_clr;    // probe counter <- 0
        logic probe_inc;    // probe counter + 1
        logic rd;           // read memory at index
        logic clr_wr;       // clear sweep write of used bit
        logic wr_cur;       // write carried entry at index, mark used
        logic wr_val;       // rewrite value only at index (replace)
        logic swap;         // carried <- read entry, plen + 1
        logic cur_inc;      // carried probe length + 1
        logic wr_shift;     // write read entry (plen-1) at previous index
        logic clr_prev;     // clear used bit at previous index
        logic prev_save;    // previous index <- index
        logic cnt_inc;
        logic cnt_dec;
        logic set_hit;      // record hit with read value
        logic [1:0] status;
        logic set_status;
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic             rd_used;
        logic             rd_match;
        logic             probe_gt;    // probe counter > read plen
        logic             cur_gt;      // carried plen > read plen
        logic             rd_plen_zero;
        logic             probe_done;  // probe counter reached SLOTS-1
        logic             clr_done;
        logic             full;
        logic [1:0]       op;
    } stat_t;

endpackage

// ===== sv/rhh_datapath.sv =====
// ============================================================================
// rhh_datapath
// Slot memory, used bits, carried entry, index and counters.
// ============================================================================
module rhh_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rhh_pkg::cmd_t                 cmd,
    output rhh_pkg::stat_t                st,
    input  logic [1:0]                    in_op,
    input  logic [rhh_pkg::KEY_BITS-1:0]  in_key,
    input  logic [rhh_pkg::HASH_BITS-1:0] in_hash,
    input  logic [rhh_pkg::VALUE_BITS-1:0] in_value,
    output logic                          found,
    output logic [rhh_pkg::VALUE_BITS-1:0] value_out,
    output logic [1:0]                    status,
    output logic [rhh_pkg::CNT_W-1:0]     item_count
);
    import rhh_pkg::*;

    entry_t             mem [SLOTS];
    logic               used_mem [SLOTS];
    entry_t             rd_reg;
    logic               rd_used_reg;
    entry_t             cur_reg;
    logic [1:0]         op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   prev_reg;
    logic [CNT_W-1:0]   probe_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W:0]     clr_reg;
    logic               found_reg;
    logic [VALUE_BITS-1:0] vout_reg;
    logic [1:0]         status_reg;
    entry_t             shift_e;
    entry_t             carry_e;

    // Shifted-back entry and displaced entry taken onward one slot
    always_comb
    begin
        shift_e      = rd_reg;
        shift_e.plen = rd_reg.plen - PL_W'(1);
        carry_e      = rd_reg;
        carry_e.plen = rd_reg.plen + PL_W'(1);
    end

    // Entry memory: one write port, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_cur)
            mem[idx_reg] <= cur_reg;
        else if (cmd.wr_shift)
            mem[prev_reg] <= shift_e;
        else if (cmd.wr_val)
            mem[idx_reg].value <= cur_reg.value;
        if (cmd.rd)
            rd_reg <= mem[idx_reg];
    end

    // Used bits: cleared by a sweep after reset
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            used_mem[clr_reg[IDX_W-1:0]] <= 1'b0;
        else if (cmd.wr_cur || cmd.wr_shift)
            used_mem[cmd.wr_cur ? idx_reg : prev_reg] <= 1'b1;
        else if (cmd.clr_prev)
            used_mem[prev_reg] <= 1'b0;
        if (cmd.rd)
            rd_used_reg <= used_mem[idx_reg];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
                clr_reg <= clr_reg + (IDX_W+1)'(1);
            if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Request, carried entry, index and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg        <= in_op;
            cur_reg.key   <= in_key;
            cur_reg.hash  <= in_hash;
            cur_reg.value <= in_value;
            cur_reg.plen  <= '0;
            found_reg     <= 1'b0;
            vout_reg      <= '0;
            status_reg    <= ST_OK;
        end
        else if (cmd.swap)
            cur_reg <= carry_e;
        else if (cmd.cur_inc)
            cur_reg.plen <= cur_reg.plen + PL_W'(1);
        if (cmd.idx_home)
            idx_reg <= cur_reg.hash[IDX_W-1:0];
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + IDX_W'(1);
        if (cmd.prev_save)
            prev_reg <= idx_reg;
        if (cmd.probe_clr)
            probe_reg <= '0;
        else if (cmd.probe_inc)
            probe_reg <= probe_reg + CNT_W'(1);
        if (cmd.set_hit)
        begin
            found_reg <= 1'b1;
            if (op_reg != OP_INSERT)
                vout_reg <= rd_reg.value;
        end
        if (cmd.set_status)
            status_reg <= cmd.status;
    end

    assign st.rd_used      = rd_used_reg;
    assign st.rd_match     = rd_reg.hash == cur_reg.hash && rd_reg.key == cur_reg.key;
    assign st.probe_gt     = PL_W'(probe_reg) > rd_reg.plen;
    assign st.cur_gt       = cur_reg.plen > rd_reg.plen;
    assign st.rd_plen_zero = rd_reg.plen == '0;
    assign st.probe_done   = probe_reg == CNT_W'(SLOTS - 1);
    assign st.clr_done     = clr_reg[IDX_W];
    assign st.full         = cnt_reg >= CNT_W'(SLOTS);
    assign st.op           = op_reg;

    assign found      = found_reg;
    assign value_out  = vout_reg;
    assign status     = status_reg;
    assign item_count = cnt_reg;

endmodule

// ===== sv/rhh_ctrl.sv =====
// ============================================================================
// rhh_ctrl
// Sequencer for find, place and backward-shift delete walks.
// ============================================================================
module rhh_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  rhh_pkg::stat_t st,
    output rhh_pkg::cmd_t  cmd
);
    import rhh_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_done)
                begin
                    cmd.clr_wr = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req  = 1'b1;
                    cmd.probe_clr = 1'b1;
                    state_next    = S_FRD;
                end
            end
            S_FRD:
            begin
                cmd.idx_home = 1'b1;
                state_next   = S_FCHK;
            end
            S_FCHK:
            begin
                // issue read at current index; check next cycle
                cmd.rd     = 1'b1;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                // evaluate find step
                if (!st.rd_used || (!st.rd_match && (st.probe_gt || st.probe_done)))
                begin
                    // miss
                    case (st.op)
                        OP_INSERT:
                        begin
                            if (st.full)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = ST_FULL;
                                state_next     = S_RESP;
                            end
                            else
                            begin
                                cmd.idx_home  = 1'b1;
                                cmd.probe_clr = 1'b1;
                                state_next    = S_PCHK;
                            end
                        end
                        default:
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NOTFOUND;
                            state_next     = S_RESP;
                        end
                    endcase
                end
                else if (st.rd_match)
                begin
                    cmd.set_hit = 1'b1;
                    case (st.op)
                        OP_INSERT:
                        begin
                            cmd.wr_val = 1'b1;
                            state_next = S_RESP;
                        end
                        OP_DELETE:
                        begin
                            cmd.cnt_dec   = 1'b1;
                            cmd.prev_save = 1'b1;
                            cmd.idx_inc   = 1'b1;
                            cmd.probe_clr = 1'b1;
                            state_next    = S_DRD;
                        end
                        default:
                            state_next = S_RESP;
                    endcase
                end
                else
                begin
                    cmd.idx_inc   = 1'b1;
                    cmd.probe_inc = 1'b1;
                    state_next    = S_FCHK;
                end
            end
            S_PCHK:
            begin
                // read the slot for the next placement step
                cmd.rd     = 1'b1;
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                // placement or shift decision, by op
                if (st.op == OP_DELETE)
                begin
                    if (!st.rd_used || st.rd_plen_zero)
                    begin
                        cmd.clr_prev = 1'b1;
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        cmd.wr_shift = 1'b1;
                        if (st.probe_done)
                            state_next = S_RESP;
                        else
                        begin
                            cmd.prev_save = 1'b1;
                            cmd.idx_inc   = 1'b1;
                            cmd.probe_inc = 1'b1;
                            state_next    = S_DRD;
                        end
                    end
                end
                else if (!st.rd_used)
                begin
                    cmd.wr_cur  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    if (st.cur_gt)
                    begin
                        cmd.wr_cur = 1'b1;
                        cmd.swap   = 1'b1;
                    end
                    cmd.cur_inc   = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    cmd.probe_inc = 1'b1;
                    state_next    = S_PCHK;
                end
            end
            S_DRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DCHK;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // A result is offered only outside the input handshake
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready and valid together");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !(cmd.wr_cur || cmd.wr_shift || cmd.wr_val))
        else $error("write while idle");

endmodule

// ===== sv/robin_hood_hash_table_top.sv =====
// ============================================================================
// robin_hood_hash_table_top
// Robin Hood hash table with backward-shift delete, 1024 slots.
// ============================================================================
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | op[1:0], key[65:2], key_hash[97:66], value[161:98]
// m_axis  | out | found[0], value_out[64:1], status[66:65], item_count[77:67]
//
// Each slot probed by the search takes a read state and a check state, as
// does each slot of insert placement or delete shift; the single read port
// of the slot RAM sets this.
// After reset a sweep clears the used bits; no request is taken until it
// ends. The result is held until m_axis_tready.
module robin_hood_hash_table_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,  // op, key, key_hash, value
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata   // found, value_out, status, item_count
);
    import rhh_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    logic [1:0]            status;
    logic [CNT_W-1:0]      item_count;

    rhh_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    rhh_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .in_op      (s_axis_tdata[1:0]),
        .in_key     (s_axis_tdata[65:2]),
        .in_hash    (s_axis_tdata[97:66]),
        .in_value   (s_axis_tdata[161:98]),
        .found      (found),
        .value_out  (value_out),
        .status     (status),
        .item_count (item_count)
    );

    assign m_axis_tdata = {2'b00, item_count, status, value_out, found};

endmodule

// ===== sim/robin_hood_hash_table_top_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// robin_hood_hash_table_top_test
// Self-checking bench for the Robin Hood hash table.
// ============================================================================
// Requests go in on s_axis and results come back on m_axis. A shadow copy of
// the table in this bench predicts every result, and each returned result is
// compared field by field with the oldest prediction. Stimulus is a short
// directed table, then a random mix on a small key pool with clustered and
// wrapping home slots, then a fill to a full table and a drain by deletes.
// ============================================================================
module robin_hood_hash_table_top_test;
    import rhh_pkg::*;

    localparam int  LIMIT_CYCLES = 30_000_000;
    localparam int  POOL         = 48;
    localparam int  HOLD_CYCLES  = 400;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        bit          found;
        logic [63:0] value_out;
        logic [1:0]  status;
        logic [10:0] item_count;
    } reply_t;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] key;
        logic [31:0] key_hash;
        logic [63:0] value;
        bit          typed;
        reply_t      want;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;

    // shadow copy of the table
    bit          shadow_used [SLOTS];
    logic [63:0] shadow_key  [SLOTS];
    logic [63:0] shadow_val  [SLOTS];
    logic [31:0] shadow_hash [SLOTS];
    int          shadow_plen [SLOTS];
    int          shadow_count;

    reply_t      pending_replies[$];
    row_t        directed_rows[$];
    logic [63:0] filled_keys[$];
    logic [31:0] filled_hashes[$];
    logic [63:0] pool_key  [POOL];
    logic [31:0] pool_hash [POOL];

    int  mismatches;
    int  replies_seen;
    int  requests_sent;
    int  full_hits;
    int  cycle_count;
    bit  calm;
    bit  hold_req;

    robin_hood_hash_table_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Search for a key; returns its slot when present
    function automatic bit shadow_find(input logic [63:0] k, input logic [31:0] h,
                                       output int where);
        int i;
        i = h & (SLOTS - 1);
        where = 0;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!shadow_used[i])
                return 1'b0;
            if (shadow_hash[i] == h && shadow_key[i] == k)
            begin
                where = i;
                return 1'b1;
            end
            if (n > shadow_plen[i])
                return 1'b0;
            i = (i + 1) & (SLOTS - 1);
        end
        return 1'b0;
    endfunction

    // Place a new key, displacing residents closer to home
    function automatic void shadow_place(input logic [63:0] k, input logic [31:0] h,
                                         input logic [63:0] v);
        logic [63:0] ck, cv, tk, tv;
        logic [31:0] ch, th;
        int          cp, tp, i;
        ck = k; cv = v; ch = h; cp = 0;
        i = h & (SLOTS - 1);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!shadow_used[i])
            begin
                shadow_used[i] = 1'b1;
                shadow_key[i]  = ck;
                shadow_val[i]  = cv;
                shadow_hash[i] = ch;
                shadow_plen[i] = cp;
                shadow_count++;
                return;
            end
            if (cp > shadow_plen[i])
            begin
                tk = shadow_key[i]; tv = shadow_val[i];
                th = shadow_hash[i]; tp = shadow_plen[i];
                shadow_key[i] = ck; shadow_val[i] = cv;
                shadow_hash[i] = ch; shadow_plen[i] = cp;
                ck = tk; cv = tv; ch = th; cp = tp;
            end
            cp++;
            i = (i + 1) & (SLOTS - 1);
        end
    endfunction

    // Empty a slot and shift the displaced run back by one
    function automatic void shadow_remove(input int at);
        int i, j;
        i = at;
        shadow_count--;
        for (int n = 0; n < SLOTS; n++)
        begin
            shadow_used[i] = 1'b0;
            j = (i + 1) & (SLOTS - 1);
            if (!shadow_used[j] || shadow_plen[j] == 0)
                break;
            shadow_used[i] = 1'b1;
            shadow_key[i]  = shadow_key[j];
            shadow_val[i]  = shadow_val[j];
            shadow_hash[i] = shadow_hash[j];
            shadow_plen[i] = shadow_plen[j] - 1;
            i = j;
        end
    endfunction

    // Apply one request to the shadow table and return its reply
    function automatic reply_t shadow_apply(input logic [1:0] op, input logic [63:0] k,
                                            input logic [31:0] h, input logic [63:0] v);
        reply_t r;
        int     where;
        bit     hit;
        hit = shadow_find(k, h, where);
        r.found     = hit;
        r.value_out = '0;
        r.status    = ST_OK;
        if (op == OP_INSERT)
        begin
            if (hit)
                shadow_val[where] = v;
            else if (shadow_count >= SLOTS)
            begin
                r.status = ST_FULL;
                full_hits++;
            end
            else
                shadow_place(k, h, v);
        end
        else if (op == OP_DELETE)
        begin
            if (hit)
            begin
                r.value_out = shadow_val[where];
                shadow_remove(where);
            end
            else
                r.status = ST_NOTFOUND;
        end
        else
        begin
            if (hit)
                r.value_out = shadow_val[where];
            else
                r.status = ST_NOTFOUND;
        end
        r.item_count = shadow_count[10:0];
        return r;
    endfunction

    // Idle the sender now and then, unless in a calm stretch
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(99) < 15)
        begin
            n = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Offer one request, wait for the transaction, record its reply
    task automatic issue(input logic [1:0] op, input logic [63:0] k, input logic [31:0] h,
                         input logic [63:0] v, input bit typed, input reply_t want);
        reply_t got;
        sender_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, v, h, k, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        got = shadow_apply(op, k, h, v);
        pending_replies.push_back(typed ? want : got);
        requests_sent++;
    endtask

    task automatic issue_random(input logic [1:0] op, input logic [63:0] k,
                                input logic [31:0] h, input logic [63:0] v);
        reply_t none;
        none = '{default: '0};
        issue(op, k, h, v, 1'b0, none);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Receiver: random stalls, calm stretches, one long hold-off on request
    initial
    begin
        int held;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    // Compare each returned result with the oldest prediction
    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", replies_seen, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
                report("unexpected result", m_axis_tdata[63:0], '0);
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tdata[0] !== want.found)
                    report("found", m_axis_tdata[0], want.found);
                if (m_axis_tdata[64:1] !== want.value_out)
                    report("value_out", m_axis_tdata[64:1], want.value_out);
                if (m_axis_tdata[66:65] !== want.status)
                    report("status", m_axis_tdata[66:65], want.status);
                if (m_axis_tdata[77:67] !== want.item_count)
                    report("item_count", m_axis_tdata[77:67], want.item_count);
            end
            replies_seen++;
        end
    end

    function automatic row_t mk(input logic [1:0] op, input logic [63:0] k,
                                input logic [31:0] h, input logic [63:0] v,
                                input bit typed, input bit f, input logic [63:0] vo,
                                input logic [1:0] st, input int cnt);
        row_t r;
        r.op = op; r.key = k; r.key_hash = h; r.value = v; r.typed = typed;
        r.want.found = f; r.want.value_out = vo; r.want.status = st;
        r.want.item_count = cnt[10:0];
        return r;
    endfunction

    // Main sequence
    initial
    begin
        logic [63:0] ones, pat;
        logic [1:0]  op;
        int          p, r, idx;
        ones = '1;
        pat  = 64'hA5A5_A5A5_A5A5_A5A5;
        mismatches = 0; replies_seen = 0; requests_sent = 0; full_hits = 0;
        cycle_count = 0; calm = 1'b0; hold_req = 1'b0;
        shadow_count = 0;
        for (int i = 0; i < SLOTS; i++)
            shadow_used[i] = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, slot extremes with wrap, replace, shift-back delete
        directed_rows.push_back(mk(OP_LOOKUP, 0, 0, 0, 1, 0, 0, ST_NOTFOUND, 0));
        directed_rows.push_back(mk(OP_DELETE, ones, '1, 0, 1, 0, 0, ST_NOTFOUND, 0));
        directed_rows.push_back(mk(OP_INSERT, ones, '1, ones, 1, 0, 0, ST_OK, 1));
        directed_rows.push_back(mk(OP_LOOKUP, ones, '1, 0, 1, 1, ones, ST_OK, 1));
        directed_rows.push_back(mk(OP_INSERT, 0, '1, 0, 1, 0, 0, ST_OK, 2));
        directed_rows.push_back(mk(OP_INSERT, 5, 0, 64'h5555_5555_5555_5555, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(OP_INSERT, ones, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(OP_LOOKUP, ones, 32'hFFFF_FFFE, 0, 1, 0, 0, ST_NOTFOUND, 4));
        directed_rows.push_back(mk(OP_UNUSED, 0, '1, ones, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(OP_INSERT, ones, '1, pat, 1, 1, 0, ST_OK, 4));
        directed_rows.push_back(mk(OP_LOOKUP, ones, '1, 0, 1, 1, pat, ST_OK, 4));
        directed_rows.push_back(mk(OP_DELETE, ones, '1, 0, 1, 1, pat, ST_OK, 3));
        directed_rows.push_back(mk(OP_LOOKUP, 0, '1, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(OP_LOOKUP, 5, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(OP_DELETE, 0, '1, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555,
                                   64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(OP_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
                                   64'h5555_5555_5555_5555, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(OP_DELETE, 5, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(OP_DELETE, 5, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(OP_LOOKUP, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
                                   0, 0, 0, 0, 0, 0));
        foreach (directed_rows[i])
            issue(directed_rows[i].op, directed_rows[i].key, directed_rows[i].key_hash,
                  directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);

        // Key pool with home slots bunched at the ends so clusters wrap
        for (int i = 0; i < POOL; i++)
        begin
            pool_key[i] = rand64();
            r = $urandom_range(3);
            if (r == 0)
                idx = $urandom_range(3);
            else if (r == 1)
                idx = SLOTS - 1 - $urandom_range(3);
            else
                idx = $urandom_range(SLOTS - 1);
            pool_hash[i] = {22'($urandom_range(32'h3F_FFFF)), 10'(idx)};
        end

        // Random mix on the pool; calm stretch in the middle, one long hold-off
        for (int n = 0; n < 400; n++)
        begin
            calm = (n >= 150 && n < 250);
            if (n == 300)
                hold_req = 1'b1;
            r = $urandom_range(99);
            op = (r < 40) ? OP_INSERT : (r < 70) ? OP_LOOKUP : (r < 95) ? OP_DELETE : OP_UNUSED;
            p = $urandom_range(POOL - 1);
            if ($urandom_range(19) == 0)
                issue_random(op, rand64(), $urandom, rand64());
            else if ($urandom_range(19) == 0)
                issue_random(op, pool_key[p], pool_hash[p] ^ (32'h1 << $urandom_range(31)),
                             rand64());
            else
                issue_random(op, pool_key[p], pool_hash[p], rand64());
        end
        calm = 1'b0;

        // Fill the table to capacity
        while (shadow_count < SLOTS)
        begin
            filled_keys.push_back(rand64());
            filled_hashes.push_back($urandom);
            issue_random(OP_INSERT, filled_keys[$], filled_hashes[$], rand64());
        end

        // Full table: rejected inserts, replaces, lookups
        for (int n = 0; n < 90; n++)
        begin
            idx = $urandom_range(filled_keys.size() - 1);
            r = $urandom_range(2);
            if (r == 0)
                issue_random(OP_INSERT, rand64(), $urandom, rand64());
            else
                issue_random(r == 1 ? OP_INSERT : OP_LOOKUP, filled_keys[idx],
                             filled_hashes[idx], rand64());
        end

        // Drain by deletes mixed with lookups and replaces
        for (int n = 0; n < 160; n++)
        begin
            idx = $urandom_range(filled_keys.size() - 1);
            r = $urandom_range(3);
            op = (r < 2) ? OP_DELETE : (r == 2) ? OP_LOOKUP : OP_INSERT;
            issue_random(op, filled_keys[idx], filled_hashes[idx], rand64());
            if (op == OP_DELETE)
            begin
                filled_keys.delete(idx);
                filled_hashes.delete(idx);
            end
        end

        // Wait for the last results, then a short tail
        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("%0d requests sent, %0d results checked, %0d rejected as table full",
                 requests_sent, replies_seen, full_hits);
        $display("covered empty table, wrapping clusters, replace, shift-back delete, full table");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
